FILE: rtl/bba_pkg.sv
// Shared constants and codes for the bitmap block allocator.
package bba_pkg;

	localparam int WORD_BITS = 32;
	localparam int BIT_SEL_BITS = 5;

	localparam int DEF_MAP_ENTRIES = 1024;
	localparam int DEF_PER_FILE_LIMIT = 6;

	localparam logic [10:0] USABLE_RESET = 11'd1024;
	localparam logic [WORD_BITS-1:0] WORD_ONE = 32'h0000_0001;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	localparam logic ST_OK = 1'b0;
	localparam logic ST_FAIL = 1'b1;

endpackage

FILE: rtl/bba_map_ram.sv
// Usage map storage: one write port, one read port, registered read data.
module bba_map_ram import bba_pkg::*; #(
	parameter int DEPTH = DEF_MAP_ENTRIES / WORD_BITS,
	parameter int AW = 5
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/bba_first_clear.sv
// Finds the lowest clear bit of one map word.
module bba_first_clear import bba_pkg::*; (
	input  logic [WORD_BITS-1:0]    word,
	output logic                    found,
	output logic [BIT_SEL_BITS-1:0] bit_idx
);

	logic [WORD_BITS-1:0] free_bits;
	logic [WORD_BITS-1:0] lowest;

	// isolate lowest set bit of the free vector, then encode it
	assign free_bits = ~word;
	assign lowest = free_bits & (~free_bits + WORD_ONE);
	assign found = |free_bits;

	always_comb begin
		bit_idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowest[i]) begin
				bit_idx = bit_idx | BIT_SEL_BITS'(i);
			end
		end
	end

endmodule

FILE: rtl/bitmap_block_allocator.sv
// Top level: first-fit bitmap block allocator with a word-serial map scan.
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+-------------------------------
//  command   | cmd, block_index, held_count              | taken when start && !busy
//  result    | status, granted_index                     | valid for one cycle on done
//  config    | usable_blocks                             | written when usable_blocks_we
//
// Scan: an allocate reads one 32-bit map word per cycle starting at word 0, keeping busy
//   high until it finds a clear bit or has read the last usable word, word ceil(limit/32) - 1
//   (word 31 at the default map size); the single map read port sets this rate.
// A free is a read-modify-write of one word: busy for one cycle.
// An allocate refused by the per-file limit or a zero usable count, and a free
//   outside the map, give their result the next cycle without going busy.
// Reset: a clearing pass writes every map word to zero, one word per cycle, with busy
//   high; config writes still land.
// The receiver cannot stall: done pulses for exactly one cycle per accepted command.
module bitmap_block_allocator import bba_pkg::*; #(
	parameter int MAP_ENTRIES = DEF_MAP_ENTRIES,
	parameter int PER_FILE_LIMIT = DEF_PER_FILE_LIMIT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        usable_blocks_we,
	input  logic [10:0] usable_blocks,
	input  logic        start,
	input  logic        cmd,
	input  logic [9:0]  block_index,
	input  logic [2:0]  held_count,
	output logic        busy,
	output logic        done,
	output logic        status,
	output logic [9:0]  granted_index
);

	localparam int MAP_WORDS = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_FREE  = 4'b1000
	} state_t;

	state_t state_q, state_nxt;
	logic [10:0] usable_q;
	logic [AW-1:0] word_q, word_nxt;
	logic [BIT_SEL_BITS-1:0] free_bit_q;
	logic done_q;
	logic status_q;
	logic [9:0] grant_q;

	// effective limit, saturated to the map size
	logic [10:0] lim;
	logic [10:0] lim_m1;
	logic [5:0] last_word;
	logic [BIT_SEL_BITS-1:0] tail_top;
	logic held_over;
	logic blk_in_map;
	logic [31:0] blk_word32;
	logic [AW-1:0] blk_addr;
	logic is_last;
	logic clear_last;
	logic accept;

	// map port
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	// scan datapath
	logic [WORD_BITS-1:0] pad;
	logic [WORD_BITS-1:0] scan_word;
	logic hit;
	logic [BIT_SEL_BITS-1:0] hit_bit;
	logic [31:0] grant_wide;

	// result
	logic res_valid;
	logic res_status;
	logic [9:0] res_grant;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done = done_q;
	assign status = status_q;
	assign granted_index = grant_q;

	assign lim = (32'(usable_q) > MAP_ENTRIES) ? 11'(MAP_ENTRIES) : usable_q;
	assign lim_m1 = lim - 11'd1;
	assign last_word = lim_m1[10:5];
	assign tail_top = lim_m1[4:0];
	assign held_over = (32'(held_count) >= PER_FILE_LIMIT);
	assign blk_in_map = (32'(block_index) < MAP_ENTRIES);
	assign blk_word32 = 32'(block_index) >> BIT_SEL_BITS;
	assign blk_addr = blk_word32[AW-1:0];
	assign is_last = (32'(word_q) == 32'(last_word));
	assign clear_last = (32'(word_q) == (MAP_WORDS - 1));

	// bits past the usable limit in the last word count as taken
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			pad[b] = is_last && (BIT_SEL_BITS'(b) > tail_top);
		end
	end

	assign scan_word = ram_rdata | pad;
	assign grant_wide = 32'({word_q, hit_bit});

	bba_first_clear u_first_clear (
		.word    (scan_word),
		.found   (hit),
		.bit_idx (hit_bit)
	);

	bba_map_ram #(
		.DEPTH (MAP_WORDS),
		.AW    (AW)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer: next state, map access, result
	always_comb begin
		state_nxt = state_q;
		word_nxt = word_q;
		ram_we = 1'b0;
		ram_waddr = word_q;
		ram_wdata = '0;
		ram_raddr = word_q;
		res_valid = 1'b0;
		res_status = ST_OK;
		res_grant = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				word_nxt = word_q + AW'(1);
				if (clear_last) begin
					state_nxt = S_IDLE;
					word_nxt = '0;
				end
			end
			S_IDLE: begin
				// read issued with the command; data arrives next cycle
				ram_raddr = (cmd == CMD_FREE) ? blk_addr : '0;
				if (accept) begin
					if (cmd == CMD_ALLOC) begin
						if (held_over || (lim == 11'd0)) begin
							res_valid = 1'b1;
							res_status = ST_FAIL;
						end else begin
							state_nxt = S_SCAN;
							word_nxt = '0;
						end
					end else if (blk_in_map) begin
						state_nxt = S_FREE;
						word_nxt = blk_addr;
					end else begin
						res_valid = 1'b1;
					end
				end
			end
			S_SCAN: begin
				ram_raddr = word_q + AW'(1);
				if (hit) begin
					ram_we = 1'b1;
					ram_wdata = ram_rdata | (WORD_ONE << hit_bit);
					res_valid = 1'b1;
					res_grant = grant_wide[9:0];
					state_nxt = S_IDLE;
				end else if (is_last) begin
					res_valid = 1'b1;
					res_status = ST_FAIL;
					state_nxt = S_IDLE;
				end else begin
					word_nxt = word_q + AW'(1);
				end
			end
			S_FREE: begin
				ram_we = 1'b1;
				ram_wdata = ram_rdata & ~(WORD_ONE << free_bit_q);
				res_valid = 1'b1;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			word_q <= '0;
			usable_q <= USABLE_RESET;
			done_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			word_q <= word_nxt;
			done_q <= res_valid;
			if (usable_blocks_we) begin
				usable_q <= usable_blocks;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			free_bit_q <= block_index[4:0];
		end
		if (res_valid) begin
			status_q <= res_status;
			grant_q <= res_grant;
		end
	end

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> 32'(word_q) <= 32'(last_word))
		else $error("scan went past the last usable word");

	a_fail_zero_grant: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q == ST_FAIL) |-> grant_q == '0)
		else $error("failed result carries a nonzero index");

	a_grant_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) && ram_we |=> (state_q == S_IDLE) && done_q)
		else $error("grant write not followed by result");

	a_quiet_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !done_q)
		else $error("result during clearing pass");

endmodule
